/* design/lpbe_pkg.sv */
// ----------------------------------------------------------------------------
// lpbe_pkg: shared types and constants of the LED PWM bit encoder
// Word types of both channels, the queue entry, the register set and the
// register index codes.
// ----------------------------------------------------------------------------
package lpbe_pkg;

   localparam int MAX_LEDS_DEFAULT           = 1024;
   localparam int COMPONENTS_PER_LED_DEFAULT = 3;
   localparam int QUEUE_DEPTH_DEFAULT        = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0] BRIGHT_FULL      = 8'd255;
   localparam logic [7:0] BRIGHT_OFF       = 8'd0;
   localparam logic [7:0] LED_SEED_STEP    = 8'd131;
   localparam logic [7:0] COMP_SEED_STEP   = 8'd17;
   localparam logic [5:0] RESET_SLOTS_MAX  = 6'd56;
   localparam logic [5:0] LAST_BIT_INDEX   = 6'd7;
   localparam logic [5:0] BITS_PER_BYTE    = 6'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORMAL_BRIGHTNESS = 3'd0,
      CSR_FORCE_ENABLE      = 3'd1,
      CSR_FORCED_BRIGHTNESS = 3'd2,
      CSR_DITHER_ENABLE     = 3'd3,
      CSR_ONE_CODE          = 3'd4,
      CSR_ZERO_CODE         = 3'd5,
      CSR_RESET_SLOTS       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  normal_brightness;
      logic        force_enable;
      logic [7:0]  forced_brightness;
      logic        dither_enable;
      logic [15:0] one_code;
      logic [15:0] zero_code;
      logic [5:0]  reset_slots;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  color_byte;
      logic [31:0] frame_tick;
      logic        last_byte;
   } req_word_type;

   typedef struct packed {
      logic [15:0] pulse_code;
      logic        run_last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] level;
      logic       last_byte;
   } queue_entry_type;

endpackage

/* design/lpbe_front.sv */
// ----------------------------------------------------------------------------
// lpbe_front: brightness scaling and dither of one colour byte
// Scales the byte by the effective brightness, applies ordered rounding,
// and tracks the LED and component position that seeds the dither.
// ----------------------------------------------------------------------------
module lpbe_front #(
   parameter int MAX_LEDS           = lpbe_pkg::MAX_LEDS_DEFAULT,
   parameter int COMPONENTS_PER_LED = lpbe_pkg::COMPONENTS_PER_LED_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lpbe_pkg::cfg_type         cfg,
   input  logic                      accept,
   input  lpbe_pkg::req_word_type    req_word,
   output lpbe_pkg::queue_entry_type entry
);
   import lpbe_pkg::*;

   localparam int LED_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int COMP_W = $clog2(COMPONENTS_PER_LED);

   logic [LED_W-1:0]  led_ff,      led_in;
   logic [COMP_W-1:0] comp_ff,     comp_in;
   logic [7:0]        led_seed_ff, led_seed_in;
   logic [7:0]        comp_seed_ff, comp_seed_in;

   logic [7:0]  bright;
   logic [15:0] prod;
   logic [16:0] prod_adj;
   logic [7:0]  q_base;
   logic [15:0] q_times;
   logic [7:0]  remainder;
   logic [7:0]  seed;
   logic        round_up;
   logic [7:0]  q_round;

   // floor(prod/255) by reciprocal: (x + x/256 + 1) / 256, exact below 65535
   always_comb begin
      bright    = cfg.force_enable ? cfg.forced_brightness : cfg.normal_brightness;
      prod      = 16'(req_word.color_byte) * 16'(bright);
      prod_adj  = {1'b0, prod} + 17'(prod[15:8]) + 17'd1;
      q_base    = prod_adj[15:8];
      q_times   = {q_base, 8'h00} - {8'h00, q_base};
      remainder = 8'(prod - q_times);
      seed      = req_word.frame_tick[7:0] + led_seed_ff + comp_seed_ff;
      round_up  = cfg.dither_enable && (remainder != 8'd0) && (seed < remainder);
      q_round   = (round_up && (q_base != BRIGHT_FULL)) ? (q_base + 8'd1) : q_base;

      entry.last_byte = req_word.last_byte;
      if (bright == BRIGHT_OFF) begin
         entry.level = 8'd0;
      end else if (bright == BRIGHT_FULL) begin
         entry.level = req_word.color_byte;
      end else begin
         entry.level = q_round;
      end
   end

   // advance position on every accepted word, drop to zero after the last one
   always_comb begin
      led_in       = led_ff;
      comp_in      = comp_ff;
      led_seed_in  = led_seed_ff;
      comp_seed_in = comp_seed_ff;
      if (accept) begin
         if (req_word.last_byte) begin
            led_in       = '0;
            comp_in      = '0;
            led_seed_in  = 8'd0;
            comp_seed_in = 8'd0;
         end else if (comp_ff == COMP_W'(COMPONENTS_PER_LED - 1)) begin
            comp_in      = '0;
            comp_seed_in = 8'd0;
            if (led_ff == LED_W'(MAX_LEDS - 1)) begin
               led_in      = '0;
               led_seed_in = 8'd0;
            end else begin
               led_in      = led_ff + LED_W'(1);
               led_seed_in = led_seed_ff + LED_SEED_STEP;
            end
         end else begin
            comp_in      = comp_ff + COMP_W'(1);
            comp_seed_in = comp_seed_ff + COMP_SEED_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff       <= '0;
         comp_ff      <= '0;
         led_seed_ff  <= 8'd0;
         comp_seed_ff <= 8'd0;
      end else begin
         led_ff       <= led_in;
         comp_ff      <= comp_in;
         led_seed_ff  <= led_seed_in;
         comp_seed_ff <= comp_seed_in;
      end
   end

endmodule

/* design/lpbe_queue.sv */
// ----------------------------------------------------------------------------
// lpbe_queue: short FIFO between front and back
// Register-based queue of scaled bytes; head entry is shown combinationally.
// ----------------------------------------------------------------------------
module lpbe_queue #(
   parameter int DEPTH = lpbe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lpbe_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output lpbe_pkg::queue_entry_type head_entry
);
   import lpbe_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/lpbe_back.sv */
// ----------------------------------------------------------------------------
// lpbe_back: bit serializer
// Shifts a scaled byte out as compare words, MSB first, then appends the
// reset slots after a frame's last byte; drives the output register.
// ----------------------------------------------------------------------------
module lpbe_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lpbe_pkg::cfg_type         cfg,
   input  logic                      head_valid,
   input  lpbe_pkg::queue_entry_type head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lpbe_pkg::rsp_word_type    rsp_word
);
   import lpbe_pkg::*;

   logic         busy_ff,   busy_in;
   logic [7:0]   shift_ff,  shift_in;
   logic [5:0]   idx_ff,    idx_in;
   logic [5:0]   end_ff,    end_in;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff,  out_word_in;

   logic       can_emit;
   logic       emit;
   logic       at_end;
   logic [5:0] slots_sat;

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_comb begin
      can_emit  = !out_valid_ff || !rsp_stall;
      emit      = busy_ff && can_emit;
      at_end    = (idx_ff == end_ff);
      slots_sat = (cfg.reset_slots > RESET_SLOTS_MAX) ? RESET_SLOTS_MAX : cfg.reset_slots;
      pop       = head_valid && (!busy_ff || (emit && at_end));

      busy_in      = busy_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         if (idx_ff < BITS_PER_BYTE) begin
            out_word_in.pulse_code = shift_ff[7] ? cfg.one_code : cfg.zero_code;
         end else begin
            out_word_in.pulse_code = 16'd0;
         end
         out_word_in.run_last = at_end;
         shift_in = {shift_ff[6:0], 1'b0};
         idx_in   = idx_ff + 6'd1;
         if (at_end) begin
            busy_in = 1'b0;
         end
      end else if (can_emit) begin
         out_valid_in = 1'b0;
      end

      // load the next byte right behind the final word of the current one
      if (pop) begin
         busy_in  = 1'b1;
         shift_in = head_entry.level;
         idx_in   = 6'd0;
         end_in   = head_entry.last_byte ? (LAST_BIT_INDEX + slots_sat) : LAST_BIT_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      out_word_ff <= out_word_in;
   end

endmodule

/* design/led_pwm_bit_encoder.sv */
// ----------------------------------------------------------------------------
// led_pwm_bit_encoder: colour byte to PWM compare word encoder
// Each request word carries one colour component byte in wire order. The
// byte is scaled by the effective brightness (forced or global), optionally
// rounded up by an ordered dither seeded from the frame tick and the LED and
// component position, and sent as eight response words, MSB first: the
// one-code for a set bit, the zero-code for a clear bit. After a byte flagged
// last, reset_slots zero words follow (at most 56) and the position counters
// return to zero. run_last marks the final response word of each request.
// Rate: the serializer emits one response word per cycle unless rsp_stall
// holds it or no byte is queued; the front scales one byte per cycle into
// a QUEUE_DEPTH-entry queue (two by default), so requests are taken in a
// burst until it fills, then at the serializer's pace. Registers must be
// written through csr_write/csr_index/csr_data only while idle; not enforced.
// ----------------------------------------------------------------------------
module led_pwm_bit_encoder #(
   parameter int MAX_LEDS           = lpbe_pkg::MAX_LEDS_DEFAULT,
   parameter int COMPONENTS_PER_LED = lpbe_pkg::COMPONENTS_PER_LED_DEFAULT,
   parameter int QUEUE_DEPTH        = lpbe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [lpbe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lpbe_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lpbe_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lpbe_pkg::rsp_word_type            rsp_word
);
   import lpbe_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            req_accept;
   logic            queue_full;
   logic            queue_pop;
   logic            head_valid;
   queue_entry_type front_entry;
   queue_entry_type head_entry;

   // register file: unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_NORMAL_BRIGHTNESS: begin
               cfg_in.normal_brightness = csr_data[7:0];
            end
            CSR_FORCE_ENABLE: begin
               cfg_in.force_enable = csr_data[0];
            end
            CSR_FORCED_BRIGHTNESS: begin
               cfg_in.forced_brightness = csr_data[7:0];
            end
            CSR_DITHER_ENABLE: begin
               cfg_in.dither_enable = csr_data[0];
            end
            CSR_ONE_CODE: begin
               cfg_in.one_code = csr_data;
            end
            CSR_ZERO_CODE: begin
               cfg_in.zero_code = csr_data;
            end
            CSR_RESET_SLOTS: begin
               cfg_in.reset_slots = csr_data[5:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_brightness <= 8'd255;
         cfg_ff.force_enable      <= 1'b0;
         cfg_ff.forced_brightness <= 8'd0;
         cfg_ff.dither_enable     <= 1'b0;
         cfg_ff.one_code          <= 16'd58;
         cfg_ff.zero_code         <= 16'd29;
         cfg_ff.reset_slots       <= 6'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold off requests only while the queue is full
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   lpbe_front #(
      .MAX_LEDS           (MAX_LEDS),
      .COMPONENTS_PER_LED (COMPONENTS_PER_LED)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (req_accept),
      .req_word (req_word),
      .entry    (front_entry)
   );

   lpbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   lpbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

/* tb/led_pwm_bit_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pwm_bit_encoder_tb: self-checking bench of the LED PWM bit encoder
// Drives colour bytes through the request channel under random gaps and
// stalls, recomputes every compare word (brightness scaling, ordered dither,
// reset slots, position counters) and checks each response word in order.
// ----------------------------------------------------------------------------
module led_pwm_bit_encoder_tb;
   import lpbe_pkg::*;

   // Spare register index: writes to it must leave every register alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE = 3'd7;
   // Cycles without any accepted word before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Bytes of one unbroken frame before its last byte, enough to walk the seed over many LEDs.
   localparam int LONG_FRAME_BYTES = 40;
   localparam int BLOCK_BYTES      = 18;
   localparam int BLOCKS_PER_MODE  = 4;

   // -------------------------------------------------------------------------
   // Compare-word predictor: own copy of the registers and the position
   // counters, and the queue of compare words still owed by the block.
   // -------------------------------------------------------------------------
   class pulse_code_board;
      cfg_type      regs;
      logic [9:0]   led_pos;
      logic [1:0]   comp_pos;
      rsp_word_type owed_codes[$];
      int           failures;
      int           words_seen;

      function new();
         regs.normal_brightness = BRIGHT_FULL;
         regs.force_enable      = 1'b0;
         regs.forced_brightness = BRIGHT_OFF;
         regs.dither_enable     = 1'b0;
         regs.one_code          = 16'd58;
         regs.zero_code         = 16'd29;
         regs.reset_slots       = 6'd50;
         led_pos    = '0;
         comp_pos   = '0;
         failures   = 0;
         words_seen = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_NORMAL_BRIGHTNESS: regs.normal_brightness = data[7:0];
            CSR_FORCE_ENABLE:      regs.force_enable      = data[0];
            CSR_FORCED_BRIGHTNESS: regs.forced_brightness = data[7:0];
            CSR_DITHER_ENABLE:     regs.dither_enable     = data[0];
            CSR_ONE_CODE:          regs.one_code          = data[15:0];
            CSR_ZERO_CODE:         regs.zero_code         = data[15:0];
            CSR_RESET_SLOTS:       regs.reset_slots       = data[5:0];
            default: ;
         endcase
      endfunction

      // Scale one byte by v*b/255, rounding up by the ordered dither.
      function logic [7:0] scaled_level(logic [7:0] level, logic [31:0] tick);
         logic [7:0]  bright;
         logic [15:0] prod;
         logic [15:0] quot;
         logic [15:0] rem;
         logic [7:0]  seed;
         bright = regs.force_enable ? regs.forced_brightness : regs.normal_brightness;
         if (bright == BRIGHT_OFF) return 8'd0;
         if (bright == BRIGHT_FULL) return level;
         prod = {8'd0, level} * {8'd0, bright};
         quot = prod / {8'd0, BRIGHT_FULL};
         rem  = prod - quot * {8'd0, BRIGHT_FULL};
         if (regs.dither_enable && rem != 16'd0) begin
            seed = tick[7:0] + led_pos[7:0] * LED_SEED_STEP + {6'd0, comp_pos} * COMP_SEED_STEP;
            if ({8'd0, seed} < rem) quot = quot + 16'd1;
         end
         if (quot > {8'd0, BRIGHT_FULL}) quot = {8'd0, BRIGHT_FULL};
         return quot[7:0];
      endfunction

      // Queue the compare words that one accepted request word causes.
      function void note_byte(req_word_type w);
         logic [7:0]   level;
         rsp_word_type code;
         int           slots;
         int           i;
         level = scaled_level(w.color_byte, w.frame_tick);
         slots = 0;
         if (w.last_byte) begin
            slots = (regs.reset_slots > RESET_SLOTS_MAX) ? int'(RESET_SLOTS_MAX)
                                                         : int'(regs.reset_slots);
         end
         for (i = 7; i >= 0; i--) begin
            code.pulse_code = level[i] ? regs.one_code : regs.zero_code;
            code.run_last   = (i == 0 && slots == 0);
            owed_codes.push_back(code);
         end
         for (i = 0; i < slots; i++) begin
            code.pulse_code = 16'd0;
            code.run_last   = (i == slots - 1);
            owed_codes.push_back(code);
         end
         // Advance the LED and component counters; clear them after a last byte.
         if (w.last_byte) begin
            led_pos  = '0;
            comp_pos = '0;
         end else if (comp_pos == 2'(COMPONENTS_PER_LED_DEFAULT - 1)) begin
            comp_pos = '0;
            led_pos  = (led_pos == 10'(MAX_LEDS_DEFAULT - 1)) ? '0 : led_pos + 10'd1;
         end else begin
            comp_pos = comp_pos + 2'd1;
         end
      endfunction

      // Compare one accepted response word with the oldest owed word.
      function void check_code(rsp_word_type got);
         rsp_word_type want;
         words_seen++;
         if (owed_codes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("word %0d: unexpected, got code %h last %b",
                        words_seen, got.pulse_code, got.run_last);
            return;
         end
         want = owed_codes.pop_front();
         if (got.pulse_code !== want.pulse_code || got.run_last !== want.run_last) begin
            failures++;
            if (failures <= 10)
               $display("word %0d: expected code %h last %b, got code %h last %b",
                        words_seen, want.pulse_code, want.run_last,
                        got.pulse_code, got.run_last);
         end
      endfunction

      function int pending();
         return owed_codes.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_valid;
   logic                   req_stall;
   req_word_type           req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_word_type           rsp_word;

   pulse_code_board board;
   int              gap_pct;
   int              stall_pct;
   int              quiet_cycles = 0;

   led_pwm_bit_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the response channel at random; change only on the falling edge.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor both channels at the rising edge. Note the request first so a
   // word accepted on the same edge is already owed when a response shows up.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_byte(req_word);
         if (rsp_valid && !rsp_stall) board.check_code(rsp_word);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      // Drop the run when nothing moves for far longer than any legal stall.
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers: every call starts and ends just after a falling edge.
   // -------------------------------------------------------------------------

   // Write one register; hold the enable for a single rising edge.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one request word, after a random gap, and hold it until taken.
   task automatic send_byte(input logic [7:0] level, input logic [31:0] tick,
                            input logic last);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_word.color_byte <= level;
      req_word.frame_tick <= tick;
      req_word.last_byte  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Lower valid and wait until every owed word has come back.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // Mostly well-formed frames: one tick per frame, last flag on the final
   // byte. About one byte in twenty flips its flag or jumps to a new tick.
   task automatic send_frame(input int len);
      logic [31:0] tick;
      logic [7:0]  level;
      logic        last;
      int          i;
      tick = $urandom();
      for (i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       level = 8'h00;
            1:       level = 8'hFF;
            default: level = 8'($urandom());
         endcase
         last = (i == len - 1);
         if ($urandom_range(0, 19) == 0) last = ~last;
         if ($urandom_range(0, 19) == 0) tick = $urandom();
         send_byte(level, tick, last);
      end
   endtask

   // Brightness with a heavy share of the edges: off, full, one step off each.
   function automatic logic [7:0] pick_brightness();
      case ($urandom_range(0, 5))
         0:       return BRIGHT_OFF;
         1:       return BRIGHT_FULL;
         2:       return 8'd1;
         3:       return 8'd254;
         default: return 8'($urandom());
      endcase
   endfunction

   // Rewrite every register with random content; put junk in unused data bits.
   task automatic shuffle_regs();
      logic [5:0] slots;
      slots = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(50, 63))
                                          : 6'($urandom_range(0, 6));
      write_reg(CSR_NORMAL_BRIGHTNESS, {8'($urandom()), pick_brightness()});
      write_reg(CSR_FORCE_ENABLE,      {15'($urandom()), 1'($urandom())});
      write_reg(CSR_FORCED_BRIGHTNESS, {8'($urandom()), pick_brightness()});
      write_reg(CSR_DITHER_ENABLE,     {15'($urandom()), 1'($urandom())});
      write_reg(CSR_ONE_CODE,          16'($urandom()));
      write_reg(CSR_ZERO_CODE,         16'($urandom()));
      write_reg(CSR_RESET_SLOTS,       {10'($urandom()), slots});
      if ($urandom_range(0, 2) == 0) write_reg(CSR_INDEX_SPARE, 16'($urandom()));
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int          mode;
      int          blk;
      int          sent;
      int          len;
      int          i;
      logic [31:0] tick;

      board        = new();
      gap_pct      = 0;
      stall_pct    = 0;
      reset        = 1'b1;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_valid    = 1'b0;
      req_word     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- Directed part ---

      // Reset values: full scale passes the byte through, 50 reset slots.
      send_byte(8'h00, 32'h0000_0000, 1'b0);
      send_byte(8'hFF, 32'h0000_0000, 1'b0);
      send_byte(8'hA5, 32'h0000_0000, 1'b1);
      wait_drain();

      // Brightness off gives all zero codes; no reset slots after the frame.
      write_reg(CSR_NORMAL_BRIGHTNESS, 16'hFF00);
      write_reg(CSR_RESET_SLOTS, 16'd0);
      send_byte(8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'h81, 32'hFFFF_FFFF, 1'b1);
      wait_drain();

      // Half brightness with dither; a slot count above range saturates.
      write_reg(CSR_NORMAL_BRIGHTNESS, 16'd128);
      write_reg(CSR_DITHER_ENABLE, 16'd1);
      write_reg(CSR_RESET_SLOTS, 16'd63);
      send_byte(8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'h01, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'h7F, 32'hFFFF_FFFF, 1'b0);
      send_byte(8'h80, 32'hFFFF_FFFF, 1'b1);
      wait_drain();

      // Forced brightness at the lowest step overrides the global value.
      write_reg(CSR_FORCE_ENABLE, 16'd1);
      write_reg(CSR_FORCED_BRIGHTNESS, 16'd1);
      write_reg(CSR_RESET_SLOTS, 16'd57);
      send_byte(8'hFF, 32'h1234_5678, 1'b0);
      send_byte(8'h80, 32'h1234_5678, 1'b0);
      send_byte(8'hFE, 32'h1234_5678, 1'b1);
      wait_drain();

      // Forced one step below full; compare words at their extremes.
      write_reg(CSR_FORCED_BRIGHTNESS, 16'd254);
      write_reg(CSR_ONE_CODE, 16'hFFFF);
      write_reg(CSR_ZERO_CODE, 16'h0000);
      send_byte(8'hFF, 32'h0000_00FF, 1'b0);
      send_byte(8'h55, 32'h0000_00FF, 1'b0);
      send_byte(8'h01, 32'h0000_00FF, 1'b1);
      wait_drain();

      // Spare index is ignored; swapped codes, full scale, 56 slots.
      write_reg(CSR_INDEX_SPARE, 16'hFFFF);
      write_reg(CSR_ONE_CODE, 16'h0000);
      write_reg(CSR_ZERO_CODE, 16'hFFFF);
      write_reg(CSR_RESET_SLOTS, 16'd56);
      write_reg(CSR_FORCE_ENABLE, 16'hFFFE);
      write_reg(CSR_NORMAL_BRIGHTNESS, 16'd255);
      send_byte(8'h3C, 32'h8000_0000, 1'b0);
      send_byte(8'hC3, 32'h8000_0000, 1'b1);
      wait_drain();

      // Lowest nonzero global brightness with the dither off.
      write_reg(CSR_NORMAL_BRIGHTNESS, 16'd1);
      write_reg(CSR_DITHER_ENABLE, 16'hFFFE);
      write_reg(CSR_RESET_SLOTS, 16'd3);
      send_byte(8'hFF, 32'hAAAA_5555, 1'b0);
      send_byte(8'h80, 32'hAAAA_5555, 1'b0);
      send_byte(8'hFF, 32'hAAAA_5555, 1'b1);
      wait_drain();

      // --- Random part ---
      // Mode 0: sender idles lightly, receiver heavily. Mode 1: the reverse.
      // Mode 2: neither side idles.
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin gap_pct = 15; stall_pct = 62; end
            1: begin gap_pct = 62; stall_pct = 15; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         for (blk = 0; blk < BLOCKS_PER_MODE; blk++) begin
            shuffle_regs();
            sent = 0;
            while (sent < BLOCK_BYTES) begin
               len = $urandom_range(1, 9);
               send_frame(len);
               sent += len;
            end
            wait_drain();
         end
      end

      // One long frame with dither on, so the seed follows the LED and
      // component position over many LEDs.
      write_reg(CSR_NORMAL_BRIGHTNESS, 16'd200);
      write_reg(CSR_FORCE_ENABLE, 16'd0);
      write_reg(CSR_DITHER_ENABLE, 16'd1);
      write_reg(CSR_RESET_SLOTS, 16'd2);
      tick = $urandom();
      for (i = 0; i < LONG_FRAME_BYTES; i++) send_byte(8'($urandom()), tick, 1'b0);
      send_byte(8'($urandom()), tick, 1'b1);

      // Drain, then give the block time to show any stray word.
      wait_drain();
      repeat (40) @(negedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
